/* rtl/pab_pkg.sv */
// Shared types, register indexes and pixel helper functions for the pixel blend/copy unit.
// No dependencies.

package pab_pkg;

	localparam int unsigned PixW  = 32;
	localparam int unsigned ChanW = 8;
	localparam int unsigned ProdW = 16;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 8;

	localparam logic [CfgIdxW-1:0] REG_SRC_MAP   = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_SRC_ALPHA = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_DST_MAP   = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_DST_ALPHA = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_BLEND     = 3'd4;

	localparam logic [ChanW-1:0] MapReset  = 8'd228;
	localparam logic [ChanW-1:0] AlphaFull = 8'hff;

	typedef struct packed {
		logic             blend;
		logic [ProdW-1:0] r;
		logic [ProdW-1:0] g;
		logic [ProdW-1:0] b;
		logic [ChanW-1:0] a;
	} stage_t;

	function automatic logic [ChanW-1:0] byte_at(input logic [PixW-1:0] word,
			input logic [1:0] idx);
		logic [ChanW-1:0] res;
		case (idx)
			2'd0: res = word[7:0];
			2'd1: res = word[15:8];
			2'd2: res = word[23:16];
			default: res = word[31:24];
		endcase
		return res;
	endfunction

	function automatic logic [PixW-1:0] place(input logic [ChanW-1:0] v,
			input logic [1:0] idx);
		logic [PixW-1:0] res;
		case (idx)
			2'd0: res = {24'd0, v};
			2'd1: res = {16'd0, v, 8'd0};
			2'd2: res = {8'd0, v, 16'd0};
			default: res = {v, 24'd0};
		endcase
		return res;
	endfunction

	// floor(x/255), exact for x below 65280
	function automatic logic [ChanW-1:0] div255(input logic [ProdW-1:0] x);
		logic [ProdW:0] t;
		t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
		return t[15:8];
	endfunction

	function automatic logic [ProdW-1:0] mix(input logic [ChanW-1:0] s,
			input logic [ChanW-1:0] d, input logic [ChanW-1:0] a);
		logic [ProdW-1:0] ps;
		logic [ProdW-1:0] pd;
		ps = ProdW'(s) * ProdW'(a);
		pd = ProdW'(d) * ProdW'(AlphaFull - a);
		return ps + pd;
	endfunction

endpackage

/* rtl/pixel_alpha_blend_copy.sv */
// Pixel blend/copy unit: unpack, source-over blend and repack of 8-bit RGBA pixels.
// Depends on pab_pkg.

// One pixel pair per clock while the output is not stalled: the first stage unpacks both words
// and, when blending, forms the three alpha products; the second divides the blend products by
// 255 and packs into the output register. Both stages stall together on m_tready; configuration
// is to be written only while no transaction is in flight.
module pixel_alpha_blend_copy (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [pab_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [pab_pkg::CfgDataW-1:0]  cfg_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [63:0]                   s_tdata,   // src_pixel [31:0], dst_pixel [63:32]
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [31:0]                   m_tdata    // out_pixel [31:0]
);

	logic [7:0] src_map_q;
	logic       src_alpha_q;
	logic [7:0] dst_map_q;
	logic       dst_alpha_q;
	logic       blend_q;

	logic              v_s1;
	pab_pkg::stage_t   st_s1;
	pab_pkg::stage_t   st_d;
	logic              v_q;
	logic [31:0]       pix_q;
	logic              out_rdy;
	logic [31:0]       sw, dw;
	logic [7:0]        sr, sg, sb, sa, dr, dg, db;
	logic [7:0]        mr, mg, mb;
	logic [31:0]       packed_pix;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_map_q   <= pab_pkg::MapReset;
			src_alpha_q <= 1'b1;
			dst_map_q   <= pab_pkg::MapReset;
			dst_alpha_q <= 1'b1;
			blend_q     <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				pab_pkg::REG_SRC_MAP:   src_map_q   <= cfg_data;
				pab_pkg::REG_SRC_ALPHA: src_alpha_q <= cfg_data[0];
				pab_pkg::REG_DST_MAP:   dst_map_q   <= cfg_data;
				pab_pkg::REG_DST_ALPHA: dst_alpha_q <= cfg_data[0];
				pab_pkg::REG_BLEND:     blend_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign out_rdy  = !v_q || m_tready;
	assign s_tready = !v_s1 || out_rdy;

	assign sw = s_tdata[31:0];
	assign dw = s_tdata[63:32];

	always_comb begin
		sr = pab_pkg::byte_at(sw, src_map_q[1:0]);
		sg = pab_pkg::byte_at(sw, src_map_q[3:2]);
		sb = pab_pkg::byte_at(sw, src_map_q[5:4]);
		sa = src_alpha_q ? pab_pkg::byte_at(sw, src_map_q[7:6]) : pab_pkg::AlphaFull;
		dr = pab_pkg::byte_at(dw, dst_map_q[1:0]);
		dg = pab_pkg::byte_at(dw, dst_map_q[3:2]);
		db = pab_pkg::byte_at(dw, dst_map_q[5:4]);
		st_d.blend = blend_q;
		if (blend_q) begin
			st_d.r = pab_pkg::mix(sr, dr, sa);
			st_d.g = pab_pkg::mix(sg, dg, sa);
			st_d.b = pab_pkg::mix(sb, db, sa);
			st_d.a = pab_pkg::AlphaFull;
		end else begin
			st_d.r = {8'd0, sr};
			st_d.g = {8'd0, sg};
			st_d.b = {8'd0, sb};
			st_d.a = sa;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			st_s1 <= st_d;
		end
	end

	always_comb begin
		if (st_s1.blend) begin
			mr = pab_pkg::div255(st_s1.r);
			mg = pab_pkg::div255(st_s1.g);
			mb = pab_pkg::div255(st_s1.b);
		end else begin
			mr = st_s1.r[7:0];
			mg = st_s1.g[7:0];
			mb = st_s1.b[7:0];
		end
		packed_pix = pab_pkg::place(mr, dst_map_q[1:0])
			+ pab_pkg::place(mg, dst_map_q[3:2])
			+ pab_pkg::place(mb, dst_map_q[5:4])
			+ (dst_alpha_q ? pab_pkg::place(st_s1.a, dst_map_q[7:6]) : 32'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (out_rdy) begin
			v_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_rdy && v_s1) begin
			pix_q <= packed_pix;
		end
	end

	assign m_tvalid = v_q;
	assign m_tdata  = pix_q;

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !out_rdy) |=> v_s1)
		else $error("stage 1 transaction lost while output stalled");

	a_out_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(v_s1))
		else $error("output valid without a stage 1 transaction");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> s_tready)
		else $error("input stalled with empty stage 1");

	a_s1_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && out_rdy && !s_tvalid) |=> !v_s1)
		else $error("stage 1 valid not cleared after hand-off");

endmodule

/* tb/sv/tb_pixel_alpha_blend_copy.sv */
// Testbench for pixel_alpha_blend_copy: directed and random pixel pairs over many register
// settings, with results checked against a built-in blend/copy predictor in arrival order.
// Depends on pab_pkg and rtl/pixel_alpha_blend_copy.sv.
`timescale 1ns / 1ps

module tb_pixel_alpha_blend_copy;

	localparam logic [pab_pkg::CfgIdxW-1:0] REG_SPARE_FIRST = 3'd5;
	localparam logic [pab_pkg::CfgIdxW-1:0] REG_SPARE_LAST  = 3'd7;
	localparam int STUCK_LIMIT  = 4000;
	localparam int HOLD_CYCLES  = 120;
	localparam int RAND_PHASES  = 12;
	localparam int PHASE_PIXELS = 70;

	class blend_checker;
		logic [7:0]  src_map;
		logic [7:0]  dst_map;
		logic        src_alpha;
		logic        dst_alpha;
		logic        blend_on;
		logic [31:0] want_pixels[$];
		int          errors;

		function new();
			src_map   = pab_pkg::MapReset;
			dst_map   = pab_pkg::MapReset;
			src_alpha = 1'b1;
			dst_alpha = 1'b1;
			blend_on  = 1'b0;
			errors    = 0;
		endfunction

		function void set_reg(logic [pab_pkg::CfgIdxW-1:0] idx, logic [7:0] val);
			case (idx)
				pab_pkg::REG_SRC_MAP:   src_map   = val;
				pab_pkg::REG_SRC_ALPHA: src_alpha = val[0];
				pab_pkg::REG_DST_MAP:   dst_map   = val;
				pab_pkg::REG_DST_ALPHA: dst_alpha = val[0];
				pab_pkg::REG_BLEND:     blend_on  = val[0];
				default: ;
			endcase
		endfunction

		function logic [31:0] predict_pixel(logic [31:0] src, logic [31:0] dst);
			logic [7:0]  sc[4];
			logic [7:0]  dc[3];
			logic [7:0]  oc[4];
			logic [31:0] acc;
			int          a;
			int          k;
			for (k = 0; k < 4; k++)
				sc[k] = 8'(src >> (8 * src_map[2*k +: 2]));
			for (k = 0; k < 3; k++)
				dc[k] = 8'(dst >> (8 * dst_map[2*k +: 2]));
			if (!src_alpha)
				sc[3] = 8'hff;
			a = int'(sc[3]);
			if (blend_on) begin
				for (k = 0; k < 3; k++)
					oc[k] = 8'((sc[k] * a + dc[k] * (255 - a)) / 255);
				oc[3] = 8'hff;
			end else begin
				oc = sc;
			end
			// colliding positions add up, carries run into higher bytes
			acc = '0;
			for (k = 0; k < 3; k++)
				acc += 32'(oc[k]) << (8 * dst_map[2*k +: 2]);
			if (dst_alpha)
				acc += 32'(oc[3]) << (8 * dst_map[7:6]);
			return acc;
		endfunction

		function void note_pair(logic [31:0] src, logic [31:0] dst);
			want_pixels.push_back(predict_pixel(src, dst));
		endfunction

		function void check_pixel(logic [31:0] got);
			logic [31:0] want;
			if (want_pixels.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected out_pixel %08h, no transaction pending", got);
				return;
			end
			want = want_pixels.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= 10)
					$display("out_pixel mismatch: expected %08h, got %08h", want, got);
			end
		endfunction

		function int pending();
			return want_pixels.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [7:0]  cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;

	blend_checker sb = new();
	int burst_left = 1;
	int stuck_cycles = 0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;

	always #6 clk = ~clk;

	pixel_alpha_blend_copy uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			sb.check_pixel(m_tdata);
		if (s_tvalid && s_tready)
			sb.note_pair(s_tdata[31:0], s_tdata[63:32]);
	end

	always @(posedge clk) begin
		if (!arst_n || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles >= STUCK_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	// receiver: segments of steady, random and alternating readiness, one long hold-off
	initial begin : rx_side
		int mode;
		int seg_len;
		int k;
		@(posedge arst_n);
		forever begin
			if (hold_req && !hold_done) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end
			mode    = $urandom_range(0, 3);
			seg_len = $urandom_range(5, 60);
			for (k = 0; k < seg_len && !(hold_req && !hold_done); k++) begin
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 3) != 0);
					2: m_tready <= (k % 2 == 0);
					default: m_tready <= ($urandom_range(0, 3) == 0);
				endcase
				@(posedge clk);
			end
		end
	end

	task automatic put_reg(input logic [pab_pkg::CfgIdxW-1:0] idx, input logic [7:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		sb.set_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_config(input logic [7:0] smap, input logic [7:0] salpha,
			input logic [7:0] dmap, input logic [7:0] dalpha, input logic [7:0] blend);
		settle();
		put_reg(pab_pkg::REG_SRC_MAP, smap);
		put_reg(pab_pkg::REG_SRC_ALPHA, salpha);
		put_reg(pab_pkg::REG_DST_MAP, dmap);
		put_reg(pab_pkg::REG_DST_ALPHA, dalpha);
		put_reg(pab_pkg::REG_BLEND, blend);
		// out-of-range index, must leave every register untouched
		put_reg($urandom_range(0, 1) ? REG_SPARE_FIRST : REG_SPARE_LAST, 8'($urandom));
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_pair(input logic [31:0] src, input logic [31:0] dst);
		s_tdata  <= {dst, src};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		burst_left--;
		if (burst_left <= 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 50);
		end
	endtask

	function automatic logic [7:0] rand_map();
		case ($urandom_range(0, 5))
			0: return 8'h00;
			1: return 8'hff;
			2: return pab_pkg::MapReset;
			3: return 8'h1b;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] rand_pixel();
		logic [31:0] w;
		int k;
		if ($urandom_range(0, 1))
			return $urandom;
		for (k = 0; k < 4; k++) begin
			case ($urandom_range(0, 4))
				0: w[8*k +: 8] = 8'h00;
				1: w[8*k +: 8] = 8'hff;
				default: w[8*k +: 8] = 8'($urandom);
			endcase
		end
		return w;
	endfunction

	initial begin : stimulus
		int ph;
		int n;
		burst_left = $urandom_range(1, 50);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: plain copy
		send_pair(32'h00000000, 32'hffffffff);
		send_pair(32'hffffffff, 32'h00000000);
		send_pair(32'h12345678, 32'h9abcdef0);

		// blend, alpha at both ends and mid-scale
		load_config(pab_pkg::MapReset, 8'h01, pab_pkg::MapReset, 8'h01, 8'hff);
		send_pair(32'h00ffffff, 32'h11223344);
		send_pair(32'hff102030, 32'hffffffff);
		send_pair(32'h80ff00ff, 32'h00ff00ff);
		send_pair(32'hffffffff, 32'hffffffff);
		send_pair(32'h00000000, 32'h00000000);
		send_pair(32'h01ffffff, 32'h00000000);

		// no source alpha via a wide value, reversed byte order
		load_config(8'h1b, 8'hfe, 8'h1b, 8'h01, 8'h01);
		send_pair(32'ha1b2c3d4, 32'h55667788);
		send_pair(32'h00000000, 32'hffffffff);

		// every channel on byte 0: sums carry upwards
		load_config(8'h00, 8'h01, 8'h00, 8'h01, 8'h00);
		send_pair(32'h000000ff, 32'h00000000);
		send_pair(32'hffffffff, 32'h00000000);
		send_pair(32'h80808080, 32'hffffffff);

		// every channel on byte 3: sums wrap past the word
		load_config(8'hff, 8'h01, 8'hff, 8'h01, 8'h00);
		send_pair(32'hff000000, 32'h00000000);
		send_pair(32'h12345678, 32'h00000000);

		// no destination alpha, alpha bits set in its map
		load_config(8'h39, 8'h01, 8'h4e, 8'h00, 8'h01);
		send_pair(32'h80aabbcc, 32'h11223344);
		send_pair(32'h40ffffff, 32'h00000000);
		send_pair(32'hc0000000, 32'hffffffff);

		for (ph = 0; ph < RAND_PHASES; ph++) begin
			load_config(rand_map(), 8'($urandom), rand_map(), 8'($urandom), 8'($urandom));
			if (ph == 2)
				hold_req = 1'b1;
			for (n = 0; n < PHASE_PIXELS; n++)
				send_pair(rand_pixel(), rand_pixel());
		end

		settle();
		repeat (4) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
